// ===== src/serial_frame_receiver_checksum_defines.svh =====
// ----------------------------------------------------------------------------
// Serial frame receiver assertion macros
// Shared assertion forms for the frame receiver checkers.
// ----------------------------------------------------------------------------
`ifndef SERIAL_FRAME_RECEIVER_CHECKSUM_DEFINES_SVH
`define SERIAL_FRAME_RECEIVER_CHECKSUM_DEFINES_SVH

// clocked check, masked while reset is asserted
`define SFRC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// clocked implication check across consecutive edges
`define SFRC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/sfrc_pkg.sv =====
// ----------------------------------------------------------------------------
// Frame receiver package
// Types, register map and status codes shared by the frame receiver.
// ----------------------------------------------------------------------------
package sfrc_pkg;

	localparam int unsigned ADDR_W = 4;
	localparam int unsigned DATA_W = 32;

	localparam logic [1:0] REG_HDR_FIRST  = 2'd0;
	localparam logic [1:0] REG_HDR_SECOND = 2'd1;
	localparam logic [1:0] REG_MAX_LEN    = 2'd2;

	localparam logic [7:0] HDR_FIRST_RST  = 8'h7A;
	localparam logic [7:0] HDR_SECOND_RST = 8'h5B;
	localparam logic [7:0] MAX_LEN_RST    = 8'd16;

	localparam logic [1:0] ST_GOOD = 2'd0;
	localparam logic [1:0] ST_CSUM = 2'd1;
	localparam logic [1:0] ST_LEN  = 2'd2;

	typedef struct packed {
		logic [7:0] header_first;
		logic [7:0] header_second;
		logic [7:0] max_len;
	} cfg_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] frame_flag;
		logic [7:0] frame_len;
		logic [7:0] command;
	} result_t;

endpackage

// ===== src/sfrc_cfg.sv =====
// ----------------------------------------------------------------------------
// Frame receiver register file
// APB-style access to the header bytes and the length limit.
// ----------------------------------------------------------------------------
module sfrc_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [sfrc_pkg::ADDR_W-1:0] paddr,
	input  logic [sfrc_pkg::DATA_W-1:0] pwdata,
	output logic [sfrc_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output sfrc_pkg::cfg_t             cfg
);
	import sfrc_pkg::*;

	cfg_t       cfg_q;
	logic [1:0] idx;
	logic       wr;
	logic [7:0] rd_byte;

	assign idx    = paddr[3:2];
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_first  <= HDR_FIRST_RST;
			cfg_q.header_second <= HDR_SECOND_RST;
			cfg_q.max_len       <= MAX_LEN_RST;
		end else if (wr) begin
			unique case (idx)
				REG_HDR_FIRST:  cfg_q.header_first  <= pwdata[7:0];
				REG_HDR_SECOND: cfg_q.header_second <= pwdata[7:0];
				REG_MAX_LEN:    cfg_q.max_len       <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_HDR_FIRST:  rd_byte = cfg_q.header_first;
			REG_HDR_SECOND: rd_byte = cfg_q.header_second;
			REG_MAX_LEN:    rd_byte = cfg_q.max_len;
			default:        rd_byte = 8'd0;
		endcase
	end

	assign prdata = {{(DATA_W-8){1'b0}}, rd_byte};

endmodule

// ===== src/sfrc_fsm.sv =====
// ----------------------------------------------------------------------------
// Frame receiver deframer
// Per-byte header hunt, field capture and running checksum.
// ----------------------------------------------------------------------------
module sfrc_fsm (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        rx_byte,
	input  sfrc_pkg::cfg_t    cfg,
	output logic              res_valid,
	output sfrc_pkg::result_t res
);
	import sfrc_pkg::*;

	typedef enum logic [2:0] {
		PH_HUNT1 = 3'd0,
		PH_HUNT2 = 3'd1,
		PH_FLAG  = 3'd2,
		PH_LEN   = 3'd3,
		PH_DATA  = 3'd4
	} phase_t;

	phase_t     phase_q, phase_d;
	logic [7:0] pos_q, pos_d;
	logic [7:0] flag_q, flag_d;
	logic [7:0] len_q, len_d;
	logic [7:0] sum_q, sum_d;
	logic [7:0] cmd_q, cmd_d;
	logic [7:0] cmd_cur;
	logic [8:0] pos_inc;
	logic       len_bad;

	assign pos_inc = {1'b0, pos_q} + 9'd1;
	assign len_bad = (rx_byte == 8'd0) || (rx_byte > cfg.max_len);
	assign cmd_cur = (pos_q == 8'd0) ? rx_byte : cmd_q;

	always_comb begin
		phase_d   = phase_q;
		pos_d     = pos_q;
		flag_d    = flag_q;
		len_d     = len_q;
		sum_d     = sum_q;
		cmd_d     = cmd_q;
		res_valid = 1'b0;
		res       = '{status: ST_GOOD, frame_flag: flag_q, frame_len: len_q, command: cmd_q};
		unique case (phase_q)
			PH_HUNT2: begin
				if (rx_byte == cfg.header_second) begin
					sum_d   = sum_q + rx_byte;
					phase_d = PH_FLAG;
				end else begin
					phase_d = PH_HUNT1;
				end
			end
			PH_FLAG: begin
				flag_d  = rx_byte;
				sum_d   = sum_q + rx_byte;
				phase_d = PH_LEN;
			end
			PH_LEN: begin
				len_d = rx_byte;
				sum_d = sum_q + rx_byte;
				pos_d = 8'd0;
				if (len_bad) begin
					phase_d   = PH_HUNT1;
					res_valid = 1'b1;
					res       = '{status: ST_LEN, frame_flag: flag_q,
						frame_len: rx_byte, command: 8'd0};
				end else begin
					phase_d = PH_DATA;
				end
			end
			PH_DATA: begin
				cmd_d = cmd_cur;
				if (pos_inc >= {1'b0, len_q}) begin
					phase_d   = PH_HUNT1;
					pos_d     = 8'd0;
					res_valid = 1'b1;
					res       = '{status: (rx_byte == sum_q) ? ST_GOOD : ST_CSUM,
						frame_flag: flag_q, frame_len: len_q, command: cmd_cur};
				end else begin
					sum_d = sum_q + rx_byte;
					pos_d = pos_inc[7:0];
				end
			end
			default: begin
				// hunting, also unused codes
				if (rx_byte == cfg.header_first) begin
					sum_d   = rx_byte;
					phase_d = PH_HUNT2;
				end else begin
					phase_d = PH_HUNT1;
				end
				pos_d = 8'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT1;
			pos_q   <= 8'd0;
			flag_q  <= 8'd0;
			len_q   <= 8'd0;
			sum_q   <= 8'd0;
			cmd_q   <= 8'd0;
		end else if (step) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			flag_q  <= flag_d;
			len_q   <= len_d;
			sum_q   <= sum_d;
			cmd_q   <= cmd_d;
		end
	end

endmodule

// ===== src/serial_frame_receiver_checksum.sv =====
// ----------------------------------------------------------------------------
// Serial frame receiver with additive checksum
// Deframes a received byte stream and reports one result per frame.
// ----------------------------------------------------------------------------
// One byte is taken per clock while the input is not stalled. A beat is
// registered at the input, runs through the deframer logic when the output
// register can advance, and its result, if any, lands in the output register.
// The input stalls only while the output register holds a result that the
// consumer is stalling. Registers: header_first at 0x0, header_second at 0x4,
// max_len at 0x8; write them only while idle.
module serial_frame_receiver_checksum (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sfrc_pkg::ADDR_W-1:0] paddr,
	input  logic [sfrc_pkg::DATA_W-1:0] pwdata,
	output logic [sfrc_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [7:0]                  rx_byte,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  status,
	output logic [7:0]                  frame_flag,
	output logic [7:0]                  frame_len,
	output logic [7:0]                  command
);
	import sfrc_pkg::*;

	cfg_t       cfg;
	result_t    res;
	result_t    res_q;
	logic       res_valid;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       out_valid_q;
	logic       adv;

	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !adv;

	sfrc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sfrc_fsm u_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (valid_s1 && adv),
		.rx_byte   (byte_s1),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1 && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1 && res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = res_q.status;
	assign frame_flag = res_q.frame_flag;
	assign frame_len  = res_q.frame_len;
	assign command    = res_q.command;

endmodule

// ===== src/sfrc_checker.sv =====
// ----------------------------------------------------------------------------
// Frame receiver port checker
// Port-level checks on the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
`include "serial_frame_receiver_checksum_defines.svh"

module sfrc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] status,
	input logic [7:0] frame_len,
	input logic [7:0] command
);
	import sfrc_pkg::*;

	`SFRC_ASSERT(a_stall_src, !in_stall || (out_valid && out_stall),
		"input stalled without output backpressure")
	`SFRC_ASSERT(a_status_code, !out_valid || status <= ST_LEN, "undefined status code")
	`SFRC_ASSERT(a_len_err_cmd, !(out_valid && status == ST_LEN) || command == 8'd0,
		"length error beat carries a command")
	`SFRC_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(status) && $stable(frame_len) && $stable(command),
		"stalled result beat changed")

endmodule

bind serial_frame_receiver_checksum sfrc_checker u_sfrc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.status    (status),
	.frame_len (frame_len),
	.command   (command)
);

// ===== tb/serial_frame_receiver_checksum_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Serial frame receiver testbench
// Feeds byte streams of well-formed, corrupted and noisy frames through the
// receiver under several header and length settings, with random gaps on the
// input and random stalls on the output. Every result beat is checked field
// by field against an in-bench deframer model; register writes are read back.
// ----------------------------------------------------------------------------
module serial_frame_receiver_checksum_tb;
	import sfrc_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 8;
	localparam int BYTES_PER_SETTING = 240;
	localparam int NUM_SETTINGS = 8;

	typedef enum logic [2:0] {
		HUNT_FIRST  = 3'd0,
		HUNT_SECOND = 3'd1,
		TAKE_FLAG   = 3'd2,
		TAKE_LEN    = 3'd3,
		TAKE_DATA   = 3'd4
	} deframe_phase_t;

	typedef struct packed {
		logic [7:0] rx;
		logic       typed;
		result_t    want;
	} stim_row_t;

	localparam result_t NO_FRAME = '0;

	// hand-computed frames at reset settings (0x7A 0x5B, max length 16)
	localparam stim_row_t DIRECTED [24] = '{
		'{8'h7A, 1'b0, NO_FRAME},
		'{8'h5B, 1'b0, NO_FRAME},
		'{8'h00, 1'b0, NO_FRAME},
		'{8'h00, 1'b1, '{ST_LEN, 8'h00, 8'h00, 8'h00}},
		'{8'h7A, 1'b0, NO_FRAME},
		'{8'h5B, 1'b0, NO_FRAME},
		'{8'hFF, 1'b0, NO_FRAME},
		'{8'h11, 1'b1, '{ST_LEN, 8'hFF, 8'h11, 8'h00}},
		'{8'h7A, 1'b0, NO_FRAME},
		'{8'h7A, 1'b0, NO_FRAME},
		'{8'h5B, 1'b0, NO_FRAME},
		'{8'h7A, 1'b0, NO_FRAME},
		'{8'h5B, 1'b0, NO_FRAME},
		'{8'h01, 1'b0, NO_FRAME},
		'{8'h01, 1'b0, NO_FRAME},
		'{8'hD7, 1'b1, '{ST_GOOD, 8'h01, 8'h01, 8'hD7}},
		'{8'h7A, 1'b0, NO_FRAME},
		'{8'h5B, 1'b0, NO_FRAME},
		'{8'h10, 1'b0, NO_FRAME},
		'{8'h02, 1'b0, NO_FRAME},
		'{8'hAB, 1'b0, NO_FRAME},
		'{8'h93, 1'b1, '{ST_CSUM, 8'h10, 8'h02, 8'hAB}},
		'{8'hFF, 1'b0, NO_FRAME},
		'{8'h00, 1'b0, NO_FRAME}
	};

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              in_valid;
	logic              in_stall;
	logic [7:0]        rx_byte;
	logic              out_valid;
	logic              out_stall;
	logic [1:0]        status;
	logic [7:0]        frame_flag;
	logic [7:0]        frame_len;
	logic [7:0]        command;

	serial_frame_receiver_checksum i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.rx_byte    (rx_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.frame_flag (frame_flag),
		.frame_len  (frame_len),
		.command    (command)
	);

	// deframer model state and its register copy
	cfg_t           cfg_now;
	deframe_phase_t dfm_phase;
	logic [7:0]     dfm_pos;
	logic [7:0]     dfm_flag;
	logic [7:0]     dfm_len;
	logic [7:0]     dfm_sum;
	logic [7:0]     dfm_cmd;

	result_t frames_due [$];

	int  n_mismatch;
	int  n_bytes;
	int  n_good;
	int  n_csum;
	int  n_len;
	int  n_settings;
	int  quiet_cycles;
	bit  in_bursting;
	bit  out_bursting;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic note_mismatch(input string what);
		if (n_mismatch < 10)
			$display("mismatch @%0t: %s", $realtime, what);
		n_mismatch++;
	endtask

	task automatic deframe_byte(input logic [7:0] b, output bit has_frame, output result_t res);
		has_frame = 1'b0;
		res = '0;
		unique case (dfm_phase)
		HUNT_SECOND: begin
			if (b == cfg_now.header_second) begin
				dfm_sum = dfm_sum + b;
				dfm_phase = TAKE_FLAG;
			end else begin
				dfm_phase = HUNT_FIRST;
			end
		end
		TAKE_FLAG: begin
			dfm_flag = b;
			dfm_sum = dfm_sum + b;
			dfm_phase = TAKE_LEN;
		end
		TAKE_LEN: begin
			dfm_len = b;
			dfm_sum = dfm_sum + b;
			dfm_pos = 8'd0;
			if (b == 8'd0 || b > cfg_now.max_len) begin
				dfm_phase = HUNT_FIRST;
				has_frame = 1'b1;
				res = '{ST_LEN, dfm_flag, dfm_len, 8'h00};
			end else begin
				dfm_phase = TAKE_DATA;
			end
		end
		TAKE_DATA: begin
			if (dfm_pos == 8'd0)
				dfm_cmd = b;
			if ({1'b0, dfm_pos} + 9'd1 >= {1'b0, dfm_len}) begin
				dfm_phase = HUNT_FIRST;
				dfm_pos = 8'd0;
				has_frame = 1'b1;
				res = '{(b == dfm_sum) ? ST_GOOD : ST_CSUM, dfm_flag, dfm_len, dfm_cmd};
			end else begin
				dfm_sum = dfm_sum + b;
				dfm_pos = dfm_pos + 8'd1;
			end
		end
		default: begin
			if (b == cfg_now.header_first) begin
				dfm_sum = b;
				dfm_phase = HUNT_SECOND;
			end else begin
				dfm_phase = HUNT_FIRST;
			end
			dfm_pos = 8'd0;
		end
		endcase
	endtask

	// one input beat; entered and left at a rising edge
	task automatic feed_byte(input logic [7:0] b, input logic typed, input result_t want);
		int gap;
		bit has_frame;
		result_t res;
		gap = in_bursting ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (in_stall);
		n_bytes++;
		deframe_byte(b, has_frame, res);
		if (typed)
			frames_due.push_back(want);
		else if (has_frame)
			frames_due.push_back(res);
	endtask

	task automatic apb_xfer(input logic wr, input logic [1:0] idx, input logic [7:0] v,
			output logic [DATA_W-1:0] rd);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= {24'h0, v};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] v);
		logic [DATA_W-1:0] rd;
		apb_xfer(1'b1, idx, v, rd);
		apb_xfer(1'b0, idx, 8'h00, rd);
		if (rd[7:0] !== v)
			note_mismatch($sformatf("reg %0d readback exp %02h got %02h", idx, v, rd[7:0]));
	endtask

	task automatic apply_setting(input logic [7:0] hf, input logic [7:0] hs,
			input logic [7:0] ml);
		write_reg(REG_HDR_FIRST, hf);
		write_reg(REG_HDR_SECOND, hs);
		write_reg(REG_MAX_LEN, ml);
		cfg_now = '{hf, hs, ml};
		n_settings++;
	endtask

	// let every result drain and the pipeline empty before touching registers
	task automatic drain;
		while (frames_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_frame;
		logic [7:0] fb [$];
		logic [7:0] len;
		logic [7:0] sum;
		logic [7:0] d;
		int r;
		int top;
		int i;
		in_bursting = ($urandom_range(0, 3) == 0);
		if ($urandom_range(0, 9) < 3) begin
			repeat ($urandom_range(1, 3))
				fb.push_back(8'($urandom_range(0, 255)));
		end
		fb.push_back(cfg_now.header_first);
		if ($urandom_range(0, 99) < 8)
			fb.push_back(cfg_now.header_second ^ 8'($urandom_range(1, 255)));
		else
			fb.push_back(cfg_now.header_second);
		fb.push_back(8'($urandom_range(0, 255)));
		r = $urandom_range(0, 99);
		top = (cfg_now.max_len < 8) ? cfg_now.max_len : 8;
		if (cfg_now.max_len == 8'd0 || r < 8)
			len = (r < 4) ? 8'd0 : 8'($urandom_range(0, 255));
		else if (r < 16 && cfg_now.max_len != 8'hFF)
			len = 8'($urandom_range(cfg_now.max_len + 1, 255));
		else if ((cfg_now.max_len <= 40 && r < 24) || r == 99)
			len = cfg_now.max_len;
		else
			len = 8'($urandom_range(1, top));
		fb.push_back(len);
		if (len != 8'd0 && len <= cfg_now.max_len) begin
			sum = 8'h00;
			for (i = 0; i < fb.size(); i++)
				if (i >= fb.size() - 4)
					sum = sum + fb[i];
			for (i = 0; i < len - 1; i++) begin
				d = 8'($urandom_range(0, 255));
				fb.push_back(d);
				sum = sum + d;
			end
			if ($urandom_range(0, 99) < 85)
				fb.push_back(sum);
			else
				fb.push_back(sum ^ 8'($urandom_range(1, 255)));
		end
		foreach (fb[k])
			feed_byte(fb[k], 1'b0, NO_FRAME);
	endtask

	initial begin : stimulus
		int p;
		int start_bytes;
		logic [7:0] hf;
		logic [7:0] hs;
		logic [7:0] ml;
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		rx_byte = 8'h00;
		out_stall = 1'b0;
		cfg_now = '{HDR_FIRST_RST, HDR_SECOND_RST, MAX_LEN_RST};
		dfm_phase = HUNT_FIRST;
		dfm_pos = '0;
		dfm_flag = '0;
		dfm_len = '0;
		dfm_sum = '0;
		dfm_cmd = '0;
		n_mismatch = 0;
		n_bytes = 0;
		n_good = 0;
		n_csum = 0;
		n_len = 0;
		n_settings = 1;
		in_bursting = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[k]) begin
			in_bursting = ($urandom_range(0, 1) == 0);
			feed_byte(DIRECTED[k].rx, DIRECTED[k].typed, DIRECTED[k].want);
		end

		for (p = 0; p < NUM_SETTINGS; p++) begin
			in_valid <= 1'b0;
			drain();
			hf = 8'($urandom_range(0, 255));
			hs = 8'($urandom_range(0, 255));
			ml = 8'($urandom_range(2, 40));
			unique case (p)
			0: begin
				hf = 8'h00;
				hs = 8'hFF;
				ml = 8'd1;
			end
			1: begin
				hf = 8'hFF;
				hs = 8'h00;
				ml = 8'hFF;
			end
			2: ml = 8'd0;
			3: hs = hf;
			default: ;
			endcase
			apply_setting(hf, hs, ml);
			start_bytes = n_bytes;
			while (n_bytes - start_bytes < BYTES_PER_SETTING)
				send_frame();
		end
		in_valid <= 1'b0;
		drain();

		$display("checked %0d frames (%0d good, %0d bad checksum, %0d bad length)",
			n_good + n_csum + n_len, n_good, n_csum, n_len);
		$display("from %0d bytes under %0d register settings", n_bytes, n_settings);
		if (n_mismatch == 0 && frames_due.size() == 0)
			$display("[serial_frame_receiver_checksum] OK");
		else
			$display("[serial_frame_receiver_checksum] ERROR");
		$finish;
	end

	initial begin : result_side
		int gap;
		int served;
		served = 0;
		out_bursting = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (served % 16 == 0)
				out_bursting = ($urandom_range(0, 3) == 0);
			gap = out_bursting ? 0 : $urandom_range(0, 16);
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
			served++;
		end
	end

	always @(posedge clk) begin : result_check
		result_t got;
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{status, frame_flag, frame_len, command};
			if (frames_due.size() == 0) begin
				note_mismatch($sformatf("unexpected beat st=%0d flag=%02h len=%02h cmd=%02h",
					got.status, got.frame_flag, got.frame_len, got.command));
			end else begin
				want = frames_due.pop_front();
				if (got.status !== want.status || got.frame_flag !== want.frame_flag ||
						got.frame_len !== want.frame_len || got.command !== want.command)
					note_mismatch($sformatf(
						"exp st=%0d flag=%02h len=%02h cmd=%02h, got st=%0d flag=%02h len=%02h cmd=%02h",
						want.status, want.frame_flag, want.frame_len, want.command,
						got.status, got.frame_flag, got.frame_len, got.command));
				unique case (want.status)
				ST_GOOD: n_good++;
				ST_CSUM: n_csum++;
				default: n_len++;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || psel || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout: no beat for %0d cycles, %0d results pending",
				QUIET_LIMIT, frames_due.size());
			$display("[serial_frame_receiver_checksum] ERROR");
			$finish;
		end
	end

	initial quiet_cycles = 0;

endmodule

// ===== sim.f =====
+incdir+src
src/sfrc_pkg.sv
src/sfrc_cfg.sv
src/sfrc_fsm.sv
src/serial_frame_receiver_checksum.sv
src/sfrc_checker.sv
tb/serial_frame_receiver_checksum_tb.sv
